>>> rtl/vlva_pkg.sv
`default_nettype none

package vlva_pkg;

  localparam int unsigned GRID_XY = 64;
  localparam int unsigned GRID_Z  = 32;
  localparam int unsigned CELLS   = GRID_XY * GRID_XY * GRID_Z;
  localparam int unsigned CELL_AW = $clog2(CELLS);

  // Counter widths that can also hold the grid size itself.
  localparam int unsigned XY_CW = $clog2(GRID_XY + 1);
  localparam int unsigned Z_CW  = $clog2(GRID_Z + 1);

  // Signed width for window bounds: a 16-bit cell index plus a reach of up to 255.
  localparam int unsigned CALC_W = 18;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned CELL_W   = 3 * CH_W;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CFG_XY_W = 7;
  localparam int unsigned CFG_Z_W  = 6;
  localparam int unsigned CFG_DW   = 7;

  localparam int unsigned DECAY_XY_REACH = 10;
  localparam int unsigned DECAY_Z_REACH  = 9;
  localparam int unsigned DECAY_MUL      = 7;
  localparam int unsigned DECAY_SHIFT    = 3;
  localparam int unsigned ADD_SHIFT      = 2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DECAY = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    REG_GRID_XY = 1'b0,
    REG_GRID_Z  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [CALC_W-1:0] lo;
    logic signed [CALC_W-1:0] hi;
  } span_t;

  // Window [c - reach, c + reach] clipped to 0 .. size-1, as a half-open span.
  function automatic span_t clip_span(input logic signed [CALC_W-1:0] c,
                                      input logic signed [CALC_W-1:0] reach,
                                      input logic signed [CALC_W-1:0] size);
    span_t s;
    s.lo = c - reach;
    s.hi = c + reach + signed'(CALC_W'(1));
    if (s.lo < 0) begin
      s.lo = '0;
    end
    if (s.hi > size) begin
      s.hi = size;
    end
    return s;
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [XY_CW-1:0] x,
                                                   input logic [XY_CW-1:0] y,
                                                   input logic [Z_CW-1:0]  z);
    return (CELL_AW'(x) * CELL_AW'(GRID_XY) + CELL_AW'(y)) * CELL_AW'(GRID_Z)
           + CELL_AW'(z);
  endfunction

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] c,
                                              input logic [CH_W-1:0] inc);
    logic [CH_W:0] s;
    s = {1'b0, c} + {1'b0, inc};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] decay_ch(input logic [CH_W-1:0] c);
    logic [CH_W+2:0] p;
    p = (CH_W + 3)'(c) * (CH_W + 3)'(DECAY_MUL);
    return p[CH_W+2:DECAY_SHIFT];
  endfunction

endpackage

`default_nettype wire

>>> rtl/vlva_ram.sv
`default_nettype none

module vlva_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/voxel_light_volume_accumulator.sv
`default_nettype none

// Voxel light volume: a 3D grid of RGB cells with 8-bit saturating channels.
// Commands enter on start_i while busy_o is low; each command gives exactly one
// result beat on done_o, one cycle wide, with red/green/blue_out_o valid in that
// cycle. The receiver cannot stall; a result is simply presented once.
// Add light and decay sweep their clipped cube through one read-modify-write
// unit over the cell RAM, one cell per cycle: the RAM read lands in the cycle
// after the address, and the update is written back in the cycle it lands.
// No-op commands (frame_ok_i low, empty window, unused opcode) and out-of-range
// reads answer straight from idle; an in-range read answers after its RAM read;
// add and decay answer after sweeping every cell of the window and a drain
// state. A full decay window is 21x21x19 cells; an add window covers up to
// GRID_XY*GRID_XY*GRID_Z cells. busy_o stays high until the result cycle, and a
// new start beat may be taken in the same cycle as a result.
// After reset the block zeroes all GRID_XY*GRID_XY*GRID_Z cells of the RAM
// (131072 as built) with busy_o high. Configuration writes on cfg_we_i are
// taken in any cycle and must only be issued while idle.
module voxel_light_volume_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [vlva_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [vlva_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [vlva_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [vlva_pkg::POS_W-1:0]  pos_z_i,
  input  logic [vlva_pkg::CH_W-1:0]          red_i,
  input  logic [vlva_pkg::CH_W-1:0]          green_i,
  input  logic [vlva_pkg::CH_W-1:0]          blue_i,
  input  logic [7:0]                         radius_i,
  input  logic                               frame_ok_i,
  output logic                               done_o,
  output logic [vlva_pkg::CH_W-1:0]          red_out_o,
  output logic [vlva_pkg::CH_W-1:0]          green_out_o,
  output logic [vlva_pkg::CH_W-1:0]          blue_out_o
);

  import vlva_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_READ
  } state_e;

  state_e state_q;

  logic [CFG_XY_W-1:0] xy_size_q;
  logic [CFG_Z_W-1:0]  z_size_q;

  logic [CELL_AW-1:0] clr_q;
  logic               pend_q;
  logic [CELL_AW-1:0] pend_addr_q;
  logic               done_q;
  logic [CH_W-1:0]    red_q, green_q, blue_q;

  op_e             op_q;
  logic [CH_W-1:0] red_inc_q, green_inc_q, blue_inc_q;
  logic [XY_CW-1:0] x_q, y_q, y_lo_q, x_hi_q, y_hi_q;
  logic [Z_CW-1:0]  z_q, z_lo_q, z_hi_q;

  // Command decode and window bounds.
  op_e                      op;
  logic signed [15:0]       cx16, cy16, cz16;
  logic signed [CALC_W-1:0] cx, cy, cz, sxy, sz, reach_xy, reach_z, one_s;
  span_t                    span_x, span_y, span_z;
  logic                     win_empty, in_range, sweep_go, read_go, accept;

  always_comb begin
    op    = op_e'(operation_i);
    one_s = signed'(CALC_W'(1));
    cx16  = pos_x_i[POS_W-1:16];
    cy16  = pos_y_i[POS_W-1:16];
    cz16  = pos_z_i[POS_W-1:16];
    cx    = CALC_W'(cx16);
    cy    = CALC_W'(cy16);
    cz    = CALC_W'(cz16);
    sxy   = (CALC_W'(xy_size_q) > CALC_W'(GRID_XY)) ? CALC_W'(GRID_XY)
                                                    : CALC_W'(xy_size_q);
    sz    = (CALC_W'(z_size_q) > CALC_W'(GRID_Z)) ? CALC_W'(GRID_Z)
                                                  : CALC_W'(z_size_q);
    if (op == OP_ADD) begin
      reach_xy = CALC_W'(radius_i);
      reach_z  = CALC_W'(radius_i);
    end else begin
      reach_xy = CALC_W'(DECAY_XY_REACH);
      reach_z  = CALC_W'(DECAY_Z_REACH);
    end
    span_x    = clip_span(cx, reach_xy, sxy);
    span_y    = clip_span(cy, reach_xy, sxy);
    span_z    = clip_span(cz, reach_z, sz);
    win_empty = (span_x.hi <= span_x.lo) || (span_y.hi <= span_y.lo) ||
                (span_z.hi <= span_z.lo);
    // The last cell along each axis reads as zero.
    in_range  = (cx >= 0) && (cy >= 0) && (cz >= 0) &&
                (cx < sxy - one_s) && (cy < sxy - one_s) && (cz < sz - one_s);
    accept    = start_i && (state_q == S_IDLE);
    sweep_go  = ((op == OP_ADD) || (op == OP_DECAY)) && frame_ok_i && !win_empty;
    read_go   = (op == OP_READ) && in_range;
  end

  // Sweep counters run z fastest, then y, then x.
  logic [XY_CW-1:0] x_inc, y_inc;
  logic [Z_CW-1:0]  z_inc;
  logic             z_wrap, y_wrap, sweep_last;

  always_comb begin
    x_inc      = x_q + XY_CW'(1);
    y_inc      = y_q + XY_CW'(1);
    z_inc      = z_q + Z_CW'(1);
    z_wrap     = (z_inc == z_hi_q);
    y_wrap     = (y_inc == y_hi_q);
    sweep_last = z_wrap && y_wrap && (x_inc == x_hi_q);
  end

  // Cell RAM ports and the shared update unit.
  logic               ram_we, ram_re;
  logic [CELL_AW-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;
  logic [CH_W-1:0]    cur_r, cur_g, cur_b, new_r, new_g, new_b;

  always_comb begin
    cur_r = ram_rdata[3*CH_W-1:2*CH_W];
    cur_g = ram_rdata[2*CH_W-1:CH_W];
    cur_b = ram_rdata[CH_W-1:0];
    if (op_q == OP_ADD) begin
      new_r = sat_add(cur_r, red_inc_q);
      new_g = sat_add(cur_g, green_inc_q);
      new_b = sat_add(cur_b, blue_inc_q);
    end else begin
      new_r = decay_ch(cur_r);
      new_g = decay_ch(cur_g);
      new_b = decay_ch(cur_b);
    end

    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = pend_q;
      ram_waddr = pend_addr_q;
      ram_wdata = {new_r, new_g, new_b};
    end

    if (state_q == S_SWEEP) begin
      ram_re    = 1'b1;
      ram_raddr = cell_addr(x_q, y_q, z_q);
    end else begin
      ram_re    = accept && read_go;
      ram_raddr = cell_addr(XY_CW'(cx), XY_CW'(cy), Z_CW'(cz));
    end
  end

  vlva_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_size_q <= CFG_XY_W'(GRID_XY);
      z_size_q  <= CFG_Z_W'(GRID_Z);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GRID_XY: xy_size_q <= cfg_wdata_i[CFG_XY_W-1:0];
        REG_GRID_Z:  z_size_q  <= cfg_wdata_i[CFG_Z_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else begin
      done_q <= 1'b0;
      pend_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CELL_AW'(1);
          if (clr_q == CELL_AW'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            if (sweep_go) begin
              state_q <= S_SWEEP;
            end else if (read_go) begin
              state_q <= S_READ;
            end else begin
              done_q  <= 1'b1;
              red_q   <= '0;
              green_q <= '0;
              blue_q  <= '0;
            end
          end
        end
        S_SWEEP: begin
          pend_q <= 1'b1;
          if (sweep_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The last cell is written back in this cycle.
          done_q  <= 1'b1;
          red_q   <= '0;
          green_q <= '0;
          blue_q  <= '0;
          state_q <= S_IDLE;
        end
        S_READ: begin
          done_q  <= 1'b1;
          red_q   <= cur_r;
          green_q <= cur_g;
          blue_q  <= cur_b;
          state_q <= S_IDLE;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op;
      red_inc_q   <= red_i >> ADD_SHIFT;
      green_inc_q <= green_i >> ADD_SHIFT;
      blue_inc_q  <= blue_i >> ADD_SHIFT;
      y_lo_q      <= XY_CW'(span_y.lo);
      z_lo_q      <= Z_CW'(span_z.lo);
      x_hi_q      <= XY_CW'(span_x.hi);
      y_hi_q      <= XY_CW'(span_y.hi);
      z_hi_q      <= Z_CW'(span_z.hi);
      x_q         <= XY_CW'(span_x.lo);
      y_q         <= XY_CW'(span_y.lo);
      z_q         <= Z_CW'(span_z.lo);
    end else if (state_q == S_SWEEP) begin
      pend_addr_q <= ram_raddr;
      if (z_wrap) begin
        z_q <= z_lo_q;
        if (y_wrap) begin
          y_q <= y_lo_q;
          x_q <= x_inc;
        end else begin
          y_q <= y_inc;
        end
      end else begin
        z_q <= z_inc;
      end
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

endmodule

`default_nettype wire

>>> rtl/vlva_checker.sv
`default_nettype none

module vlva_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic [1:0]                operation_i,
  input logic                      done_o,
  input logic [vlva_pkg::CH_W-1:0] red_out_o,
  input logic [vlva_pkg::CH_W-1:0] green_out_o,
  input logic [vlva_pkg::CH_W-1:0] blue_out_o
);

  import vlva_pkg::*;

  // An accepted beat either answers in the next cycle or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("accepted command neither answered nor busy");

  // A result only shows once the block has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // No result appears without a command accepted or in progress just before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result without a command");

  // Commands other than a read that do not go busy answer with all channels zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i != OP_READ)) |=>
      (busy_o || ((red_out_o == '0) && (green_out_o == '0) && (blue_out_o == '0))))
    else $error("non-read command returned nonzero channels");

endmodule

bind voxel_light_volume_accumulator vlva_checker u_vlva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .operation_i (operation_i),
  .done_o      (done_o),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o)
);

`default_nettype wire
